// ===== hw/rtl/bpt_pkg.sv =====
// Shared constants and types for the barycentric point-in-triangle core.
// Used by every module and interface of the block; no dependencies.
`default_nettype none

package bpt_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned WEIGHT_BITS    = 32;
  // Quotient bits resolved by the divider: integer, fraction and one rounding bit.
  localparam int unsigned QUOT_BITS      = WEIGHT_BITS + 1;
  localparam int unsigned DIV_STEPS      = 3;
  localparam int unsigned REG_IDX_BITS   = 3;
  localparam int unsigned NUM_REGS       = 6;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_COLLINEAR = 2'd0,
    ST_INSIDE    = 2'd1,
    ST_EDGE      = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== hw/rtl/bpt_if.sv =====
// Valid/ready channel interfaces of the barycentric point-in-triangle core.
// Depends on bpt_pkg for register index and weight widths.
`default_nettype none

interface bpt_in_if #(
  parameter int unsigned CW = bpt_pkg::COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bpt_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              status;
  logic signed [bpt_pkg::WEIGHT_BITS-1:0]  weight_a;
  logic signed [bpt_pkg::WEIGHT_BITS-1:0]  weight_b;
  logic signed [bpt_pkg::WEIGHT_BITS-1:0]  weight_c;

  modport source (output valid, status, weight_a, weight_b, weight_c, input ready);
  modport sink   (input valid, status, weight_a, weight_b, weight_c, output ready);
endinterface

interface bpt_cfg_if #(
  parameter int unsigned CW = bpt_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [bpt_pkg::REG_IDX_BITS-1:0]  index;
  logic [CW-1:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/barycentric_point_in_triangle_core.sv =====
// Top level of the barycentric point-in-triangle core.
// Depends on bpt_pkg, bpt_if, bpt_cfg, bpt_front and bpt_div.
//
// The triangle is loaded through cfg_if, one vertex coordinate per item,
// register index 0 to 5 for ax, ay, bx, by, cx, cy; other indexes are
// ignored. cfg_if is always ready. Points may be sent from the cycle after
// the last write; the determinant settles through the difference, product
// and determinant registers before an item reaches the stage that uses it.
// Each point item on in_if gives one result item on out_if: a status and
// three saturated Q15.16 weights. The pipeline accepts one item per cycle
// while out_if is not stalled. An item passes six front stages for the
// numerators and the status, then a divider of one setup stage, eleven
// stages of three quotient bits each and one rounding stage.
// When out_if is stalled with a result waiting, the whole pipeline holds and
// in_if drops ready; no item is lost or repeated. Reset clears the vertices,
// the determinant and all valid bits.
`default_nettype none

module barycentric_point_in_triangle_core import bpt_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bpt_in_if.sink     in_if,
  bpt_cfg_if.sink    cfg_if,
  bpt_out_if.source  out_if
);
  localparam int unsigned NW     = 2 * COORD_BITS + 5;
  localparam int unsigned FRONT  = 6;
  localparam int unsigned DIVLAT = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS + 2;
  localparam int unsigned LAT    = FRONT + DIVLAT;

  logic                          en;
  logic [LAT-1:0]                vld_q;
  status_e                       st_q [DIVLAT];
  logic signed [COORD_BITS-1:0]  cx, cy;
  logic signed [COORD_BITS:0]    dbycy, dcxbx, daxcx, dcyay;
  logic signed [NW-1:0]          det;
  logic [NW-1:0]                 mag_a, mag_b, mag_c, den;
  logic                          neg_a, neg_b, neg_c;
  status_e                       status_f;

  assign en           = !vld_q[LAT-1] || out_if.ready;
  assign in_if.ready  = en;
  assign cfg_if.ready = 1'b1;

  bpt_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_if.valid),
    .idx_i   (cfg_if.index),
    .data_i  (cfg_if.data),
    .cx_o    (cx),
    .cy_o    (cy),
    .dbycy_o (dbycy),
    .dcxbx_o (dcxbx),
    .daxcx_o (daxcx),
    .dcyay_o (dcyay),
    .det_o   (det)
  );

  bpt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .px_i     (in_if.point_x),
    .py_i     (in_if.point_y),
    .cx_i     (cx),
    .cy_i     (cy),
    .dbycy_i  (dbycy),
    .dcxbx_i  (dcxbx),
    .daxcx_i  (daxcx),
    .dcyay_i  (dcyay),
    .det_i    (det),
    .mag_a_o  (mag_a),
    .mag_b_o  (mag_b),
    .mag_c_o  (mag_c),
    .den_o    (den),
    .neg_a_o  (neg_a),
    .neg_b_o  (neg_b),
    .neg_c_o  (neg_c),
    .status_o (status_f)
  );

  bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_a), .den_i (den), .neg_i (neg_a),
    .weight_o (out_if.weight_a)
  );

  bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_b), .den_i (den), .neg_i (neg_b),
    .weight_o (out_if.weight_b)
  );

  bpt_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_c (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_c), .den_i (den), .neg_i (neg_c),
    .weight_o (out_if.weight_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= status_f;
      for (int i = 1; i < DIVLAT; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end
  end

  assign out_if.valid  = vld_q[LAT-1];
  assign out_if.status = st_q[DIVLAT-1];

`ifndef SYNTHESIS
  a_coll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == ST_COLLINEAR |->
      out_if.weight_a == '0 && out_if.weight_b == '0 && out_if.weight_c == '0)
    else $error("collinear result with nonzero weight");

  a_inside_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == ST_INSIDE |->
      !out_if.weight_a[WEIGHT_BITS-1] && !out_if.weight_b[WEIGHT_BITS-1] &&
      !out_if.weight_c[WEIGHT_BITS-1])
    else $error("inside result with negative weight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |->
      !in_if.ready ##1 (out_if.valid && $stable(out_if.status) &&
                        $stable(out_if.weight_a)))
    else $error("pipeline advanced while output stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bpt_cfg.sv =====
// Vertex registers, edge differences and triangle determinant.
// Depends on bpt_pkg.
`default_nettype none

module bpt_cfg import bpt_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            wr_i,
  input  wire [REG_IDX_BITS-1:0]         idx_i,
  input  wire [COORD_BITS-1:0]           data_i,
  output logic signed [COORD_BITS-1:0]   cx_o,
  output logic signed [COORD_BITS-1:0]   cy_o,
  output logic signed [COORD_BITS:0]     dbycy_o,
  output logic signed [COORD_BITS:0]     dcxbx_o,
  output logic signed [COORD_BITS:0]     daxcx_o,
  output logic signed [COORD_BITS:0]     dcyay_o,
  output logic signed [2*COORD_BITS+4:0] det_o
);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = 2 * COORD_BITS + 5;

  logic signed [COORD_BITS-1:0] vtx_q [NUM_REGS];
  logic signed [DW-1:0] dbycy_q, dcxbx_q, daxcx_q, dcyay_q;
  logic signed [PW-1:0] p0_q, p1_q;
  logic signed [NW-1:0] det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        vtx_q[i] <= '0;
      end
    end else if (wr_i) begin
      case (reg_idx_e'(idx_i))
        REG_AX: vtx_q[REG_AX] <= data_i;
        REG_AY: vtx_q[REG_AY] <= data_i;
        REG_BX: vtx_q[REG_BX] <= data_i;
        REG_BY: vtx_q[REG_BY] <= data_i;
        REG_CX: vtx_q[REG_CX] <= data_i;
        REG_CY: vtx_q[REG_CY] <= data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbycy_q <= '0;
      dcxbx_q <= '0;
      daxcx_q <= '0;
      dcyay_q <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      det_q   <= '0;
    end else begin
      dbycy_q <= DW'(vtx_q[REG_BY]) - DW'(vtx_q[REG_CY]);
      dcxbx_q <= DW'(vtx_q[REG_CX]) - DW'(vtx_q[REG_BX]);
      daxcx_q <= DW'(vtx_q[REG_AX]) - DW'(vtx_q[REG_CX]);
      dcyay_q <= DW'(vtx_q[REG_CY]) - DW'(vtx_q[REG_AY]);
      p0_q    <= PW'(dbycy_q) * PW'(daxcx_q);
      p1_q    <= PW'(dcxbx_q) * PW'(dcyay_q);
      det_q   <= NW'(p0_q) - NW'(p1_q);
    end
  end

  assign cx_o    = vtx_q[REG_CX];
  assign cy_o    = vtx_q[REG_CY];
  assign dbycy_o = dbycy_q;
  assign dcxbx_o = dcxbx_q;
  assign daxcx_o = daxcx_q;
  assign dcyay_o = dcyay_q;
  assign det_o   = det_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpt_front.sv =====
// Six-stage front pipeline: numerators, sign normalization and status.
// Depends on bpt_pkg; feeds three bpt_div lanes.
`default_nettype none

module bpt_front import bpt_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire signed [COORD_BITS-1:0]    px_i,
  input  wire signed [COORD_BITS-1:0]    py_i,
  input  wire signed [COORD_BITS-1:0]    cx_i,
  input  wire signed [COORD_BITS-1:0]    cy_i,
  input  wire signed [COORD_BITS:0]      dbycy_i,
  input  wire signed [COORD_BITS:0]      dcxbx_i,
  input  wire signed [COORD_BITS:0]      daxcx_i,
  input  wire signed [COORD_BITS:0]      dcyay_i,
  input  wire signed [2*COORD_BITS+4:0]  det_i,
  output logic [2*COORD_BITS+4:0]        mag_a_o,
  output logic [2*COORD_BITS+4:0]        mag_b_o,
  output logic [2*COORD_BITS+4:0]        mag_c_o,
  output logic [2*COORD_BITS+4:0]        den_o,
  output logic                           neg_a_o,
  output logic                           neg_b_o,
  output logic                           neg_c_o,
  output status_e                        status_o
);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = 2 * COORD_BITS + 5;

  logic signed [DW-1:0] dpx_q, dpy_q;
  logic signed [PW-1:0] pa0_q, pa1_q, pb0_q, pb1_q;
  logic signed [NW-1:0] na3_q, nb3_q;
  logic signed [NW-1:0] na4_q, nb4_q, nc4_q, det4_q;
  logic                 coll4_q;
  logic signed [NW-1:0] na5_q, nb5_q, nc5_q, det5_q;
  logic                 coll5_q;
  logic [NW-1:0]        mag_a_q, mag_b_q, mag_c_q, den_q;
  logic                 neg_a_q, neg_b_q, neg_c_q;
  status_e              status_q, status_d;

  always_comb begin
    if (coll5_q) begin
      status_d = ST_COLLINEAR;
    end else if (na5_q < 0 || nb5_q < 0 || nc5_q < 0) begin
      status_d = ST_OUTSIDE;
    end else if (na5_q == '0 || nb5_q == '0 || nc5_q == '0) begin
      status_d = ST_EDGE;
    end else begin
      status_d = ST_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dpx_q   <= DW'(px_i) - DW'(cx_i);
      dpy_q   <= DW'(py_i) - DW'(cy_i);
      pa0_q   <= PW'(dbycy_i) * PW'(dpx_q);
      pa1_q   <= PW'(dcxbx_i) * PW'(dpy_q);
      pb0_q   <= PW'(dcyay_i) * PW'(dpx_q);
      pb1_q   <= PW'(daxcx_i) * PW'(dpy_q);
      na3_q   <= NW'(pa0_q) + NW'(pa1_q);
      nb3_q   <= NW'(pb0_q) + NW'(pb1_q);
      na4_q   <= na3_q;
      nb4_q   <= nb3_q;
      nc4_q   <= det_i - na3_q - nb3_q;
      det4_q  <= det_i;
      coll4_q <= (det_i == '0);
      if (det4_q < 0) begin
        na5_q  <= -na4_q;
        nb5_q  <= -nb4_q;
        nc5_q  <= -nc4_q;
        det5_q <= -det4_q;
      end else begin
        na5_q  <= na4_q;
        nb5_q  <= nb4_q;
        nc5_q  <= nc4_q;
        det5_q <= det4_q;
      end
      coll5_q  <= coll4_q;
      status_q <= status_d;
      if (coll5_q) begin
        mag_a_q <= '0;
        mag_b_q <= '0;
        mag_c_q <= '0;
        den_q   <= NW'(1);
        neg_a_q <= 1'b0;
        neg_b_q <= 1'b0;
        neg_c_q <= 1'b0;
      end else begin
        mag_a_q <= (na5_q < 0) ? NW'(-na5_q) : NW'(na5_q);
        mag_b_q <= (nb5_q < 0) ? NW'(-nb5_q) : NW'(nb5_q);
        mag_c_q <= (nc5_q < 0) ? NW'(-nc5_q) : NW'(nc5_q);
        den_q   <= NW'(det5_q);
        neg_a_q <= na5_q < 0;
        neg_b_q <= nb5_q < 0;
        neg_c_q <= nc5_q < 0;
      end
    end
  end

  assign mag_a_o  = mag_a_q;
  assign mag_b_o  = mag_b_q;
  assign mag_c_o  = mag_c_q;
  assign den_o    = den_q;
  assign neg_a_o  = neg_a_q;
  assign neg_b_o  = neg_b_q;
  assign neg_c_o  = neg_c_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpt_div.sv =====
// Pipelined restoring divider producing one rounded, saturated fixed-point weight.
// Depends on bpt_pkg; resolves DIV_STEPS quotient bits per stage.
`default_nettype none

module bpt_div import bpt_pkg::*; #(
  parameter int unsigned NW        = 2 * COORD_BITS_DEF + 5,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire [NW-1:0]                  mag_i,
  input  wire [NW-1:0]                  den_i,
  input  wire                           neg_i,
  output logic signed [WEIGHT_BITS-1:0] weight_o
);
  localparam int unsigned RW   = NW + QUOT_BITS;
  localparam int unsigned NSTG = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned IB   = WEIGHT_BITS - FRAC_BITS;
  localparam logic [QUOT_BITS-1:0] POS_MAX = QUOT_BITS'({1'b0, {(WEIGHT_BITS-1){1'b1}}});
  localparam logic [QUOT_BITS-1:0] NEG_MAX = QUOT_BITS'({1'b1, {(WEIGHT_BITS-1){1'b0}}});

  logic [RW-1:0]        rem_q [NSTG+1];
  logic [RW-1:0]        dv_q  [NSTG+1];
  logic [QUOT_BITS-1:0] quo_q [NSTG+1];
  logic                 neg_q [NSTG+1];
  logic                 sat_q [NSTG+1];
  logic [RW-1:0]        rem_d [NSTG];
  logic [QUOT_BITS-1:0] quo_d [NSTG];
  logic [QUOT_BITS:0]   inc;
  logic [QUOT_BITS-1:0] qr;
  logic signed [WEIGHT_BITS-1:0] weight_d, weight_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(mag_i) << (FRAC_BITS + 1);
      dv_q[0]  <= RW'(den_i);
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      sat_q[0] <= RW'(mag_i) >= (RW'(den_i) << IB);
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    always_comb begin
      logic [RW-1:0] r;
      logic [RW-1:0] t;
      logic [QUOT_BITS-1:0] q;
      int k;
      r = rem_q[s];
      q = quo_q[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        k = int'(QUOT_BITS) - 1 - s * int'(DIV_STEPS) - j;
        if (k >= 0) begin
          t = dv_q[s] << k;
          if (r >= t) begin
            r = r - t;
            q = q | (QUOT_BITS'(1) << k);
          end
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d[s];
        quo_q[s+1] <= quo_d[s];
        dv_q[s+1]  <= dv_q[s];
        neg_q[s+1] <= neg_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  always_comb begin
    inc = {1'b0, quo_q[NSTG]} + (QUOT_BITS+1)'(1);
    qr  = inc[QUOT_BITS:1];
    if (!neg_q[NSTG]) begin
      if (sat_q[NSTG] || qr > POS_MAX) begin
        weight_d = WEIGHT_BITS'(POS_MAX);
      end else begin
        weight_d = WEIGHT_BITS'(qr);
      end
    end else if (sat_q[NSTG] || qr >= NEG_MAX) begin
      weight_d = WEIGHT_BITS'(NEG_MAX);
    end else begin
      weight_d = -WEIGHT_BITS'(qr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_q <= weight_d;
    end
  end

  assign weight_o = weight_q;

endmodule

`default_nettype wire
